/* hdl/cnf_text_stream_parser_macros.svh */
// Assertion macros shared by the CNF text parser modules.
// Expects clk and rst_n (synchronous, active low) in the enclosing module.
`ifndef CNF_TEXT_STREAM_PARSER_MACROS_SVH
`define CNF_TEXT_STREAM_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CTSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CTSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ctsp_pkg.sv */
// Shared types and constants for the CNF text stream parser.
// No dependencies; used by ctsp_core, ctsp_outq and cnf_text_stream_parser.
`default_nettype none

package ctsp_pkg;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_COMMENT = 7'b0000010,
    MODE_SKIP1   = 7'b0000100,
    MODE_VARS    = 7'b0001000,
    MODE_SKIP2   = 7'b0010000,
    MODE_CLAUSES = 7'b0100000,
    MODE_NUMBER  = 7'b1000000
  } mode_t;

  localparam logic [1:0] KIND_LITERAL    = 2'd0;
  localparam logic [1:0] KIND_CLAUSE_END = 2'd1;
  localparam logic [1:0] KIND_HEADER     = 2'd2;
  localparam logic [1:0] KIND_SUMMARY    = 2'd3;

  localparam logic [7:0] CHAR_C       = 8'h63;
  localparam logic [7:0] CHAR_P       = 8'h70;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic [31:0] LIT_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  // Result queue: room for two results per transaction plus slack
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] literal;
    logic [31:0]        var_count;
    logic [31:0]        clause_count;
    logic [31:0]        clauses_seen;
    logic               count_match;
    logic               overflow;
    logic               last;
  } result_t;

  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

`default_nettype wire

/* hdl/ctsp_core.sv */
// Parser state and per-byte next-state logic for the CNF text stream parser.
// Depends on ctsp_pkg and cnf_text_stream_parser_macros.svh.
`default_nettype none
`include "cnf_text_stream_parser_macros.svh"

module ctsp_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_accept,
  input  wire logic [7:0]     text_byte,
  input  wire logic           end_of_text,
  output ctsp_pkg::push_t     push
);

  ctsp_pkg::mode_t mode_r, mode_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] hvars_r, hvars_nxt;
  logic [31:0] hcl_r, hcl_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  logic        is_dig;
  logic [3:0]  digit;
  logic [35:0] mac;
  logic [35:0] limit;
  logic        mac_sat;
  logic [31:0] mac_val;
  logic [31:0] cnt_inc;
  ctsp_pkg::result_t num_res;
  ctsp_pkg::result_t hdr_res;
  ctsp_pkg::result_t sum_res;

  always_comb begin
    is_dig  = text_byte inside {[ctsp_pkg::CHAR_ZERO:ctsp_pkg::CHAR_NINE]};
    digit   = text_byte[3:0];
    // acc * 10 + digit as two shifted adds
    mac     = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {32'd0, digit};
    limit   = (mode_r == ctsp_pkg::MODE_NUMBER) ? {4'd0, ctsp_pkg::LIT_MAX}
                                                : {4'd0, ctsp_pkg::CNT_MAX};
    mac_sat = mac > limit;
    mac_val = mac_sat ? limit[31:0] : mac[31:0];
    cnt_inc = ((acc_r == 32'd0) && (cnt_r != ctsp_pkg::CNT_MAX)) ? cnt_r + 32'd1 : cnt_r;

    num_res              = '0;
    num_res.kind         = (acc_r == 32'd0) ? ctsp_pkg::KIND_CLAUSE_END
                                            : ctsp_pkg::KIND_LITERAL;
    num_res.literal      = (acc_r == 32'd0) ? 32'sd0
                         : (neg_r ? 32'd0 - acc_r : acc_r);
    num_res.var_count    = hvars_r;
    num_res.clause_count = hcl_r;
    num_res.clauses_seen = cnt_inc;
    num_res.overflow     = ovf_r;
    num_res.last         = 1'b1;

    hdr_res              = '0;
    hdr_res.kind         = ctsp_pkg::KIND_HEADER;
    hdr_res.var_count    = hvars_r;
    hdr_res.clause_count = acc_r;
    hdr_res.clauses_seen = cnt_r;
    hdr_res.overflow     = ovf_r;
    hdr_res.last         = 1'b1;

    sum_res              = '0;
    sum_res.kind         = ctsp_pkg::KIND_SUMMARY;
    sum_res.var_count    = hvars_r;
    sum_res.clause_count = hcl_r;
    sum_res.clauses_seen = cnt_r;
    sum_res.last         = 1'b1;

    mode_nxt  = mode_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    ovf_nxt   = ovf_r;
    hvars_nxt = hvars_r;
    hcl_nxt   = hcl_r;
    cnt_nxt   = cnt_r;
    push      = '0;

    if (end_of_text) begin
      // flush whatever is pending, then summarise and return to reset
      if (mode_r == ctsp_pkg::MODE_NUMBER) begin
        push.push0           = 1'b1;
        push.res0            = num_res;
        push.res0.last       = 1'b0;
        sum_res.clauses_seen = cnt_inc;
      end else if (mode_r == ctsp_pkg::MODE_CLAUSES) begin
        push.push0           = 1'b1;
        push.res0            = hdr_res;
        push.res0.last       = 1'b0;
        sum_res.clause_count = acc_r;
      end
      sum_res.count_match = (sum_res.clauses_seen == sum_res.clause_count);
      if (push.push0) begin
        push.push1 = 1'b1;
        push.res1  = sum_res;
      end else begin
        push.push0 = 1'b1;
        push.res0  = sum_res;
      end
      mode_nxt  = ctsp_pkg::MODE_IDLE;
      neg_nxt   = 1'b0;
      acc_nxt   = 32'd0;
      ovf_nxt   = 1'b0;
      hvars_nxt = 32'd0;
      hcl_nxt   = 32'd0;
      cnt_nxt   = 32'd0;
    end else begin
      case (mode_r)
        ctsp_pkg::MODE_COMMENT: begin
          if (text_byte == ctsp_pkg::CHAR_NEWLINE) begin
            mode_nxt = ctsp_pkg::MODE_IDLE;
          end
        end
        ctsp_pkg::MODE_SKIP1, ctsp_pkg::MODE_SKIP2: begin
          if (is_dig) begin
            acc_nxt  = {28'd0, digit};
            mode_nxt = (mode_r == ctsp_pkg::MODE_SKIP1) ? ctsp_pkg::MODE_VARS
                                                       : ctsp_pkg::MODE_CLAUSES;
          end
        end
        ctsp_pkg::MODE_VARS: begin
          if (is_dig) begin
            acc_nxt = mac_val;
            if (mac_sat) begin
              ovf_nxt = 1'b1;
            end
          end else begin
            // overflow flag stays up for the rest of the header
            hvars_nxt = acc_r;
            acc_nxt   = 32'd0;
            mode_nxt  = ctsp_pkg::MODE_SKIP2;
          end
        end
        ctsp_pkg::MODE_CLAUSES: begin
          if (is_dig) begin
            acc_nxt = mac_val;
            if (mac_sat) begin
              ovf_nxt = 1'b1;
            end
          end else begin
            push.push0 = 1'b1;
            push.res0  = hdr_res;
            hcl_nxt    = acc_r;
            acc_nxt    = 32'd0;
            ovf_nxt    = 1'b0;
            mode_nxt   = ctsp_pkg::MODE_IDLE;
          end
        end
        ctsp_pkg::MODE_NUMBER: begin
          if (is_dig) begin
            acc_nxt = mac_val;
            if (mac_sat) begin
              ovf_nxt = 1'b1;
            end
          end else begin
            push.push0 = 1'b1;
            push.res0  = num_res;
            cnt_nxt    = cnt_inc;
            neg_nxt    = 1'b0;
            acc_nxt    = 32'd0;
            ovf_nxt    = 1'b0;
            mode_nxt   = ctsp_pkg::MODE_IDLE;
          end
        end
        default: begin
          mode_nxt = ctsp_pkg::MODE_IDLE;
          if (text_byte == ctsp_pkg::CHAR_C) begin
            mode_nxt = ctsp_pkg::MODE_COMMENT;
          end else if (text_byte == ctsp_pkg::CHAR_P) begin
            hvars_nxt = 32'd0;
            hcl_nxt   = 32'd0;
            acc_nxt   = 32'd0;
            ovf_nxt   = 1'b0;
            mode_nxt  = ctsp_pkg::MODE_SKIP1;
          end else if (text_byte == ctsp_pkg::CHAR_MINUS) begin
            neg_nxt = 1'b1;
          end else if (is_dig) begin
            acc_nxt  = {28'd0, digit};
            ovf_nxt  = 1'b0;
            mode_nxt = ctsp_pkg::MODE_NUMBER;
          end
        end
      endcase
    end

    // nothing leaves the core unless the byte is actually taken
    if (!in_accept) begin
      push.push0 = 1'b0;
      push.push1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ctsp_pkg::MODE_IDLE;
      neg_r   <= 1'b0;
      acc_r   <= 32'd0;
      ovf_r   <= 1'b0;
      hvars_r <= 32'd0;
      hcl_r   <= 32'd0;
      cnt_r   <= 32'd0;
    end else if (in_accept) begin
      mode_r  <= mode_nxt;
      neg_r   <= neg_nxt;
      acc_r   <= acc_nxt;
      ovf_r   <= ovf_nxt;
      hvars_r <= hvars_nxt;
      hcl_r   <= hcl_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  `CTSP_ASSERT_NEXT(a_eot_resets, in_accept && end_of_text,
    mode_r == ctsp_pkg::MODE_IDLE && acc_r == 32'd0 && cnt_r == 32'd0 && !neg_r,
    "end of text did not return the parser to its reset state")
  `CTSP_ASSERT_NOW(a_two_only_at_eot, push.push1,
    end_of_text && push.push0 && push.res1.kind == ctsp_pkg::KIND_SUMMARY,
    "second result pushed outside an end-of-text transaction")
  `CTSP_ASSERT_NOW(a_lit_in_range,
    push.push0 && push.res0.kind == ctsp_pkg::KIND_LITERAL,
    push.res0.literal != 32'sd0 && push.res0.literal != 32'sh8000_0000,
    "literal out of its saturated range")

endmodule

`default_nettype wire

/* hdl/ctsp_outq.sv */
// Result queue for the CNF text stream parser: takes up to two results per
// transaction and hands one per cycle to a ready output. Depends on ctsp_pkg.
`default_nettype none
`include "cnf_text_stream_parser_macros.svh"

module ctsp_outq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ctsp_pkg::push_t   push,
  output logic                   space,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output ctsp_pkg::result_t      res
);

  ctsp_pkg::result_t q_r [ctsp_pkg::Q_DEPTH];
  logic [ctsp_pkg::Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ctsp_pkg::Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ctsp_pkg::Q_CNT_W-1:0] count_r, count_nxt;
  logic [ctsp_pkg::Q_PTR_W-1:0] wr_ptr_p1;
  logic [1:0]                   push_n;
  logic                         pop;

  always_comb begin
    pop        = res_valid && res_ready;
    push_n     = {1'b0, push.push0} + {1'b0, push.push1};
    wr_ptr_p1  = wr_ptr_r + ctsp_pkg::Q_PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + push_n[ctsp_pkg::Q_PTR_W-1:0];
    rd_ptr_nxt = rd_ptr_r + {{(ctsp_pkg::Q_PTR_W-1){1'b0}}, pop};
    count_nxt  = count_r + {{(ctsp_pkg::Q_CNT_W-2){1'b0}}, push_n}
               - {{(ctsp_pkg::Q_CNT_W-1){1'b0}}, pop};
  end

  // accept only while two slots are guaranteed free
  assign space     = count_r <= ctsp_pkg::Q_CNT_W'(ctsp_pkg::Q_DEPTH - 2);
  assign res_valid = count_r != '0;
  assign res       = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_r[wr_ptr_r] <= push.res0;
    end
    if (push.push1) begin
      q_r[wr_ptr_p1] <= push.res1;
    end
  end

  `CTSP_ASSERT_NOW(a_no_overfill, push.push0,
    count_r <= ctsp_pkg::Q_CNT_W'(ctsp_pkg::Q_DEPTH - 2),
    "result pushed without room for two entries")
  `CTSP_ASSERT_NEXT(a_count_track, 1'b1,
    count_r == $past(count_r) + {{(ctsp_pkg::Q_CNT_W-2){1'b0}}, $past(push_n)}
               - {{(ctsp_pkg::Q_CNT_W-1){1'b0}}, $past(pop)},
    "queue occupancy lost track of pushes and pops")
  `CTSP_ASSERT_NOW(a_count_bound, 1'b1,
    count_r <= ctsp_pkg::Q_CNT_W'(ctsp_pkg::Q_DEPTH),
    "queue occupancy above its depth")

endmodule

`default_nettype wire

/* hdl/cnf_text_stream_parser.sv */
// Top level of the CNF text stream parser: byte input channel, result channel.
// Depends on ctsp_pkg, ctsp_core and ctsp_outq.
//
//   channel | ports  | tdata                     | tuser       | tlast
//   input   | in_*   | text_byte                 | end_of_text | -
//   result  | out_*  | literal .. overflow       | kind        | last
//
// One byte is taken per cycle while in_tready is high; each costs one multiply-add
// by ten and a mode update, and its results go into a four-entry result queue.
// An end-of-text transaction yields one or two results; in_tready stays high
// while the queue holds two results or fewer, so output stalls back-pressure.
// Reset (rst_n low, synchronous) clears the parser state and the queue.
`default_nettype none

module cnf_text_stream_parser (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] text_byte
  input  wire logic         in_tuser,   // [0] end_of_text
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // [31:0] literal, [63:32] var_count,
                                        // [95:64] clause_count, [127:96] clauses_seen,
                                        // [128] count_match, [129] overflow, rest zero
  output logic [1:0]        out_tuser,  // [1:0] kind
  output logic              out_tlast
);

  logic              in_accept;
  ctsp_pkg::push_t   push;
  ctsp_pkg::result_t res;

  assign in_accept = in_tvalid && in_tready;

  ctsp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_accept   (in_accept),
    .text_byte   (in_tdata),
    .end_of_text (in_tuser),
    .push        (push)
  );

  ctsp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (in_tready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {6'd0, res.overflow, res.count_match, res.clauses_seen,
                      res.clause_count, res.var_count, res.literal};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

`default_nettype wire
